// ===== sv/auip_pkg.sv =====
// Package for the ASCII unsigned integer parser.
// Holds the parse state type, phase codes, character constants and helper functions.
// Used by auip_step and ascii_unsigned_integer_parser.
`default_nettype none

package auip_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_RADIX = 3'd0;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_DETECT = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;

  typedef struct packed {
    logic [2:0]  phase;
    logic [5:0]  base;
    logic [63:0] accum;
    logic [15:0] offset;
  } state_t;

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [1:0] n);
    logic [16:0] t;
    t = {1'b0, a} + {15'b0, n};
    return t[16] ? 16'hFFFF : t[15:0];
  endfunction

  function automatic logic [7:0] digit_code(logic [7:0] c);
    logic [7:0] r;
    if (c >= CH_LC_A) begin
      r = c - CH_LC_A + 8'd10;
    end else if (c >= CH_UC_A) begin
      r = c - CH_UC_A + 8'd10;
    end else begin
      r = c - CH_ZERO;
    end
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

`default_nettype wire

// ===== sv/ascii_unsigned_integer_parser.sv =====
// Top level of the ASCII unsigned integer parser: input register, parse state,
// result register and the radix register behind an APB-style port.
// Depends on auip_pkg and auip_step.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_stall_o   start_req_i, ch_i
//   out       output     out_valid_o / out_stall_i value_o, end_offset_o
//   config    input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// The block takes one byte item every cycle unless the input stalls; the parse
// state feeds back through one multiply-add of the accumulator by the base, which
// sets the cycle time. The byte ending the string loads the result register.
// Reset clears the radix to automatic detection and puts the parser idle.
// A stalled result holds in the output register; the input stalls only when
// the result register is full and stalled while a byte waits in the input register.
`default_nettype none

module ascii_unsigned_integer_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         start_req_i,
  input  logic [7:0]                   ch_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [63:0]                  value_o,
  output logic [15:0]                  end_offset_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [auip_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic             in_vld_q;
  logic             start_q;
  logic [7:0]       ch_q;
  logic             out_vld_q;
  logic [63:0]      value_q;
  logic [15:0]      offset_q;
  logic [5:0]       radix_q;
  auip_pkg::state_t state_q;
  auip_pkg::state_t state_d;
  logic             emit;
  logic             adv;
  logic             take;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign take       = in_valid_i && !in_stall_o;

  auip_step u_step (
    .cur_i   (state_q),
    .start_i (start_q),
    .ch_i    (ch_q),
    .radix_i (radix_q),
    .nxt_o   (state_d),
    .emit_o  (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      start_q <= start_req_i;
      ch_q    <= ch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      value_q  <= state_d.accum;
      offset_q <= state_d.offset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= auip_pkg::BASE_AUTO;
    end else if (psel && penable && pwrite && (paddr == auip_pkg::ADDR_RADIX)) begin
      radix_q <= pwdata[5:0];
    end
  end

  assign prdata       = (paddr == auip_pkg::ADDR_RADIX) ? {26'd0, radix_q} : 32'd0;
  assign pready       = 1'b1;
  assign out_valid_o  = out_vld_q;
  assign value_o      = value_q;
  assign end_offset_o = offset_q;

endmodule

`default_nettype wire

// ===== sv/auip_step.sv =====
// Next-state logic of the parser for one text byte.
// Takes the current parse state and the byte, gives the next state and a result strobe.
// Depends on auip_pkg.
`default_nettype none

module auip_step (
  input  auip_pkg::state_t cur_i,
  input  logic             start_i,
  input  logic [7:0]       ch_i,
  input  logic [5:0]       radix_i,
  output auip_pkg::state_t nxt_o,
  output logic             emit_o
);

  logic [2:0]  ph;
  logic [5:0]  base;
  logic [63:0] acc;
  logic [15:0] off;
  logic        go;
  logic        emit;
  logic [7:0]  dig;

  assign dig = auip_pkg::digit_code(ch_i);

  always_comb begin
    ph   = start_i ? auip_pkg::PH_SPACE : cur_i.phase;
    base = start_i ? radix_i : cur_i.base;
    acc  = start_i ? 64'd0 : cur_i.accum;
    off  = start_i ? 16'd0 : cur_i.offset;
    go   = (ph != auip_pkg::PH_IDLE);
    emit = 1'b0;

    if (go && (ph == auip_pkg::PH_SPACE)) begin
      if (auip_pkg::is_space(ch_i)) begin
        off = auip_pkg::sat_add(off, 2'd1);
        go  = 1'b0;
      end else begin
        ph = auip_pkg::PH_DETECT;
        if (ch_i == auip_pkg::CH_PLUS) begin
          off = auip_pkg::sat_add(off, 2'd1);
          go  = 1'b0;
        end
      end
    end

    if (go && (ph == auip_pkg::PH_DETECT)) begin
      if (base == auip_pkg::BASE_AUTO) begin
        if (ch_i == auip_pkg::CH_ZERO) begin
          ph = auip_pkg::PH_ZERO;
          go = 1'b0;
        end else begin
          base = auip_pkg::BASE_DEC;
        end
      end
      if (go) begin
        ph = auip_pkg::PH_DIGITS;
      end
    end

    if (go && (ph == auip_pkg::PH_ZERO)) begin
      ph = auip_pkg::PH_DIGITS;
      if ((ch_i == auip_pkg::CH_LC_X) || (ch_i == auip_pkg::CH_UC_X)) begin
        base = auip_pkg::BASE_HEX;
        off  = auip_pkg::sat_add(off, 2'd2);
        go   = 1'b0;
      end else begin
        // The leading zero counts as an octal digit of value zero.
        base = auip_pkg::BASE_OCT;
        acc  = 64'd0;
        off  = auip_pkg::sat_add(off, 2'd1);
      end
    end

    if (go && (ph == auip_pkg::PH_DIGITS)) begin
      if ((ch_i != auip_pkg::CH_NUL) && (dig < {2'b00, base})) begin
        acc = (acc * {58'd0, base}) + {56'd0, dig};
        off = auip_pkg::sat_add(off, 2'd1);
      end else begin
        emit = 1'b1;
        ph   = auip_pkg::PH_IDLE;
      end
    end

    nxt_o.phase  = ph;
    nxt_o.base   = base;
    nxt_o.accum  = acc;
    nxt_o.offset = off;
    emit_o       = emit;
  end

endmodule

`default_nettype wire

// ===== sv/auip_checker.sv =====
// Port-level checks for the ASCII unsigned integer parser, bound to its top level.
// Depends on ascii_unsigned_integer_parser.
`default_nettype none

module auip_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [63:0]                  value_o,
  input logic [15:0]                  end_offset_o,
  input logic [31:0]                  prdata,
  input logic                         pready
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(end_offset_o))
    else $error("stalled result changed");

  // The input stalls only while a result is held back by the receiver.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // The radix register is six bits wide and reads back zero above them.
  a_prdata_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:6] == 26'd0)
    else $error("register read has bits set above the radix field");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("configuration port not ready");

endmodule

bind ascii_unsigned_integer_parser auip_checker u_auip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .value_o      (value_o),
  .end_offset_o (end_offset_o),
  .prdata       (prdata),
  .pready       (pready)
);

`default_nettype wire
